// ===== rtl/core/situ_pkg.sv =====
// Shared types and widths for the segment intersection test unit.
// Used by situ_cell and segment_intersection_test_unit; no dependencies.
package situ_pkg;

    // Q16.16 point format
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    // Coordinate differences and exact cross product widths
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int CROSS_W   = PROD_W + 1;
    localparam int MAG_W     = CROSS_W - 1;
    // Quotient bits resolved by the divider row, and remainder width
    localparam int QUO_W     = COORD_W + 1;
    localparam int REM_W     = MAG_W + QUO_W;
    localparam int NUM_CELLS = QUO_W;

    // One divider lane as it moves down the cell row
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // Per-item data that travels alongside the dividers
    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [DIFF_W-1:0]  ab_x;
        logic signed [DIFF_W-1:0]  ab_y;
        logic                      parallel;
        logic                      meet;
        logic                      neg_ab;
        logic                      neg_cd;
        logic                      ovf_ab;
        logic                      ovf_cd;
    } side_t;

endpackage

// ===== rtl/core/situ_cell.sv =====
// One restoring-division step for both fraction dividers, plus side data.
// Depends on situ_pkg.
module situ_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  situ_pkg::side_t   in_side,
    input  situ_pkg::div_lane_t in_ab,
    input  situ_pkg::div_lane_t in_cd,
    output logic              out_valid,
    output situ_pkg::side_t   out_side,
    output situ_pkg::div_lane_t out_ab,
    output situ_pkg::div_lane_t out_cd
);
    import situ_pkg::*;

    logic      valid_reg;
    side_t     side_reg;
    div_lane_t ab_reg;
    div_lane_t cd_reg;
    div_lane_t ab_next;
    div_lane_t cd_next;

    // Compare remainder to divisor aligned at the top quotient bit, subtract, shift
    function automatic div_lane_t div_step(div_lane_t l);
        logic [REM_W-1:0] dsh;
        logic [REM_W-1:0] diff;
        logic             ge;
        div_lane_t        r;
        dsh  = {l.den, {(REM_W-MAG_W){1'b0}}} >> 1;
        ge   = (l.rem >= dsh);
        diff = ge ? (l.rem - dsh) : l.rem;
        r.rem = {diff[REM_W-2:0], 1'b0};
        r.den = l.den;
        r.quo = {l.quo[QUO_W-2:0], ge};
        return r;
    endfunction

    assign ab_next = div_step(in_ab);
    assign cd_next = div_step(in_cd);

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        ab_reg   <= ab_next;
        cd_reg   <= cd_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_ab    = ab_reg;
    assign out_cd    = cd_reg;

endmodule

// ===== rtl/core/segment_intersection_test_unit.sv =====
// 2D segment intersection test, Q16.16 fixed point; depends on situ_pkg, situ_cell.
// The result strobe done follows the start transfer through these registered stages:
// four front stages (differences, products, cross sums, magnitudes), a row of
// 33 division cells (one quotient bit per cell), saturation, point multiply, output.
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset: rst_n clears all valid flags, so no strobe appears until items arrive.
module segment_intersection_test_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [situ_pkg::COORD_W-1:0] a_x,
    input  logic signed [situ_pkg::COORD_W-1:0] a_y,
    input  logic signed [situ_pkg::COORD_W-1:0] b_x,
    input  logic signed [situ_pkg::COORD_W-1:0] b_y,
    input  logic signed [situ_pkg::COORD_W-1:0] c_x,
    input  logic signed [situ_pkg::COORD_W-1:0] c_y,
    input  logic signed [situ_pkg::COORD_W-1:0] d_x,
    input  logic signed [situ_pkg::COORD_W-1:0] d_y,
    output logic                                done,
    output logic signed [situ_pkg::COORD_W-1:0] frac_ab,
    output logic signed [situ_pkg::COORD_W-1:0] frac_cd,
    output logic signed [situ_pkg::COORD_W-1:0] cross_x,
    output logic signed [situ_pkg::COORD_W-1:0] cross_y,
    output logic                                segments_meet
);
    import situ_pkg::*;

    localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam int PT_W  = COORD_W + DIFF_W;
    localparam int SUM_W = PT_W + 1;

    // Pipeline never stalls
    assign busy = 1'b0;

    // ---------------- Stage 1: differences ----------------
    logic                     s1_valid_reg;
    logic signed [COORD_W-1:0] s1_ax_reg, s1_ay_reg;
    logic signed [DIFF_W-1:0]  s1_abx_reg, s1_aby_reg, s1_cdx_reg, s1_cdy_reg;
    logic signed [DIFF_W-1:0]  s1_acx_reg, s1_acy_reg;

    always_ff @(posedge clk)
    begin
        s1_ax_reg  <= a_x;
        s1_ay_reg  <= a_y;
        s1_abx_reg <= DIFF_W'(b_x) - DIFF_W'(a_x);
        s1_aby_reg <= DIFF_W'(b_y) - DIFF_W'(a_y);
        s1_cdx_reg <= DIFF_W'(d_x) - DIFF_W'(c_x);
        s1_cdy_reg <= DIFF_W'(d_y) - DIFF_W'(c_y);
        s1_acx_reg <= DIFF_W'(a_x) - DIFF_W'(c_x);
        s1_acy_reg <= DIFF_W'(a_y) - DIFF_W'(c_y);
    end

    // ---------------- Stage 2: six exact products ----------------
    logic                     s2_valid_reg;
    logic signed [COORD_W-1:0] s2_ax_reg, s2_ay_reg;
    logic signed [DIFF_W-1:0]  s2_abx_reg, s2_aby_reg;
    logic signed [PROD_W-1:0]  s2_p0_reg, s2_p1_reg, s2_p2_reg;
    logic signed [PROD_W-1:0]  s2_p3_reg, s2_p4_reg, s2_p5_reg;

    always_ff @(posedge clk)
    begin
        s2_ax_reg  <= s1_ax_reg;
        s2_ay_reg  <= s1_ay_reg;
        s2_abx_reg <= s1_abx_reg;
        s2_aby_reg <= s1_aby_reg;
        s2_p0_reg  <= PROD_W'(s1_abx_reg) * PROD_W'(s1_cdy_reg);
        s2_p1_reg  <= PROD_W'(s1_aby_reg) * PROD_W'(s1_cdx_reg);
        s2_p2_reg  <= PROD_W'(s1_acy_reg) * PROD_W'(s1_cdx_reg);
        s2_p3_reg  <= PROD_W'(s1_acx_reg) * PROD_W'(s1_cdy_reg);
        s2_p4_reg  <= PROD_W'(s1_acx_reg) * PROD_W'(s1_aby_reg);
        s2_p5_reg  <= PROD_W'(s1_acy_reg) * PROD_W'(s1_abx_reg);
    end

    // ---------------- Stage 3: cross sums ----------------
    logic                      s3_valid_reg;
    logic signed [COORD_W-1:0] s3_ax_reg, s3_ay_reg;
    logic signed [DIFF_W-1:0]  s3_abx_reg, s3_aby_reg;
    logic signed [CROSS_W-1:0] s3_den_reg, s3_nab_reg, s3_ncd_reg;

    always_ff @(posedge clk)
    begin
        s3_ax_reg  <= s2_ax_reg;
        s3_ay_reg  <= s2_ay_reg;
        s3_abx_reg <= s2_abx_reg;
        s3_aby_reg <= s2_aby_reg;
        s3_den_reg <= CROSS_W'(s2_p0_reg) - CROSS_W'(s2_p1_reg);
        s3_nab_reg <= CROSS_W'(s2_p2_reg) - CROSS_W'(s2_p3_reg);
        s3_ncd_reg <= CROSS_W'(s2_p4_reg) - CROSS_W'(s2_p5_reg);
    end

    // ---------------- Stage 4: magnitudes, signs, range flag ----------------
    logic [CROSS_W-1:0] den_abs, nab_abs, ncd_abs;
    logic [MAG_W-1:0]   den_mag, nab_mag, ncd_mag;
    logic [REM_W-1:0]   nab_scaled, ncd_scaled, den_limit;
    logic               den_neg, nab_neg, ncd_neg;
    logic               in_ab, in_cd;
    side_t              s4_side_next;
    div_lane_t          s4_ab_next, s4_cd_next;
    logic               s4_valid_reg;
    side_t              s4_side_reg;
    div_lane_t          s4_ab_reg, s4_cd_reg;

    always_comb
    begin
        den_neg = s3_den_reg[CROSS_W-1];
        nab_neg = s3_nab_reg[CROSS_W-1];
        ncd_neg = s3_ncd_reg[CROSS_W-1];
        den_abs = den_neg ? CROSS_W'(-s3_den_reg) : CROSS_W'(s3_den_reg);
        nab_abs = nab_neg ? CROSS_W'(-s3_nab_reg) : CROSS_W'(s3_nab_reg);
        ncd_abs = ncd_neg ? CROSS_W'(-s3_ncd_reg) : CROSS_W'(s3_ncd_reg);
        den_mag = den_abs[MAG_W-1:0];
        nab_mag = nab_abs[MAG_W-1:0];
        ncd_mag = ncd_abs[MAG_W-1:0];

        nab_scaled = {{(REM_W-MAG_W-FRAC_BITS){1'b0}}, nab_mag, {FRAC_BITS{1'b0}}};
        ncd_scaled = {{(REM_W-MAG_W-FRAC_BITS){1'b0}}, ncd_mag, {FRAC_BITS{1'b0}}};
        den_limit  = {den_mag, {QUO_W{1'b0}}};

        // 0 <= num/den <= 1; divisor for CD is the negated cross product
        in_ab = (nab_mag == '0) || ((nab_neg == den_neg) && (nab_mag <= den_mag));
        in_cd = (ncd_mag == '0) || ((ncd_neg != den_neg) && (ncd_mag <= den_mag));

        s4_side_next.a_x      = s3_ax_reg;
        s4_side_next.a_y      = s3_ay_reg;
        s4_side_next.ab_x     = s3_abx_reg;
        s4_side_next.ab_y     = s3_aby_reg;
        s4_side_next.parallel = (den_mag == '0);
        s4_side_next.meet     = (den_mag == '0) || (in_ab && in_cd);
        s4_side_next.neg_ab   = nab_neg ^ den_neg;
        s4_side_next.neg_cd   = ncd_neg ^ ~den_neg;
        s4_side_next.ovf_ab   = (nab_scaled >= den_limit);
        s4_side_next.ovf_cd   = (ncd_scaled >= den_limit);

        s4_ab_next.rem = nab_scaled;
        s4_ab_next.den = den_mag;
        s4_ab_next.quo = '0;
        s4_cd_next.rem = ncd_scaled;
        s4_cd_next.den = den_mag;
        s4_cd_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        s4_side_reg <= s4_side_next;
        s4_ab_reg   <= s4_ab_next;
        s4_cd_reg   <= s4_cd_next;
    end

    // ---------------- Divider cell row ----------------
    logic      row_valid [0:NUM_CELLS];
    side_t     row_side  [0:NUM_CELLS];
    div_lane_t row_ab    [0:NUM_CELLS];
    div_lane_t row_cd    [0:NUM_CELLS];

    assign row_valid[0] = s4_valid_reg;
    assign row_side[0]  = s4_side_reg;
    assign row_ab[0]    = s4_ab_reg;
    assign row_cd[0]    = s4_cd_reg;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        situ_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (row_valid[i]),
            .in_side   (row_side[i]),
            .in_ab     (row_ab[i]),
            .in_cd     (row_cd[i]),
            .out_valid (row_valid[i+1]),
            .out_side  (row_side[i+1]),
            .out_ab    (row_ab[i+1]),
            .out_cd    (row_cd[i+1])
        );
    end

    // ---------------- Saturation of the fractions ----------------
    side_t                     dv_side;
    logic [QUO_W-1:0]          q_ab, q_cd;
    logic signed [COORD_W-1:0] fab_next, fcd_next;
    logic                      sat_valid_reg;
    side_t                     sat_side_reg;
    logic signed [COORD_W-1:0] sat_fab_reg, sat_fcd_reg;

    function automatic logic signed [COORD_W-1:0] sat_quo(
        input logic [QUO_W-1:0] q,
        input logic             neg,
        input logic             ovf
    );
        logic [QUO_W-1:0] neg_lim;
        neg_lim = {1'b0, 1'b1, {(QUO_W-2){1'b0}}};
        if (neg)
        begin
            if (ovf || (q > neg_lim))
                return SAT_MIN;
            return COORD_W'(-q[COORD_W-1:0]);
        end
        if (ovf || q[QUO_W-1] || q[QUO_W-2])
            return SAT_MAX;
        return COORD_W'(q[COORD_W-1:0]);
    endfunction

    always_comb
    begin
        dv_side = row_side[NUM_CELLS];
        q_ab    = row_ab[NUM_CELLS].quo;
        q_cd    = row_cd[NUM_CELLS].quo;
        if (dv_side.parallel)
        begin
            fab_next = '0;
            fcd_next = '0;
        end
        else
        begin
            fab_next = sat_quo(q_ab, dv_side.neg_ab, dv_side.ovf_ab);
            fcd_next = sat_quo(q_cd, dv_side.neg_cd, dv_side.ovf_cd);
        end
    end

    always_ff @(posedge clk)
    begin
        sat_side_reg <= dv_side;
        sat_fab_reg  <= fab_next;
        sat_fcd_reg  <= fcd_next;
    end

    // ---------------- Point products ----------------
    logic                      mul_valid_reg;
    logic signed [COORD_W-1:0] mul_ax_reg, mul_ay_reg, mul_fab_reg, mul_fcd_reg;
    logic                      mul_meet_reg;
    logic signed [PT_W-1:0]    mul_px_reg, mul_py_reg;

    always_ff @(posedge clk)
    begin
        mul_ax_reg   <= sat_side_reg.a_x;
        mul_ay_reg   <= sat_side_reg.a_y;
        mul_fab_reg  <= sat_fab_reg;
        mul_fcd_reg  <= sat_fcd_reg;
        mul_meet_reg <= sat_side_reg.meet;
        mul_px_reg   <= PT_W'(sat_fab_reg) * PT_W'(sat_side_reg.ab_x);
        mul_py_reg   <= PT_W'(sat_fab_reg) * PT_W'(sat_side_reg.ab_y);
    end

    // ---------------- Floor shift, add base, saturate ----------------
    function automatic logic signed [COORD_W-1:0] point_sat(
        input logic signed [COORD_W-1:0] base,
        input logic signed [PT_W-1:0]    prod
    );
        logic signed [PT_W-1:0]  t;
        logic signed [SUM_W-1:0] s;
        t = prod >>> FRAC_BITS;
        s = SUM_W'(base) + SUM_W'(t);
        if (s > SUM_W'(SAT_MAX))
            return SAT_MAX;
        if (s < SUM_W'(SAT_MIN))
            return SAT_MIN;
        return s[COORD_W-1:0];
    endfunction

    logic                      out_valid_reg;
    logic signed [COORD_W-1:0] out_fab_reg, out_fcd_reg, out_x_reg, out_y_reg;
    logic                      out_meet_reg;

    always_ff @(posedge clk)
    begin
        out_fab_reg  <= mul_fab_reg;
        out_fcd_reg  <= mul_fcd_reg;
        out_x_reg    <= point_sat(mul_ax_reg, mul_px_reg);
        out_y_reg    <= point_sat(mul_ay_reg, mul_py_reg);
        out_meet_reg <= mul_meet_reg;
    end

    // ---------------- Valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            sat_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= start & ~busy;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            sat_valid_reg <= row_valid[NUM_CELLS];
            mul_valid_reg <= sat_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    assign done          = out_valid_reg;
    assign frac_ab       = out_fab_reg;
    assign frac_cd       = out_fcd_reg;
    assign cross_x       = out_x_reg;
    assign cross_y       = out_y_reg;
    assign segments_meet = out_meet_reg;

endmodule

// ===== verif/situ_checker.sv =====
// Checker for segment_intersection_test_unit: watches start/done transfers,
// predicts each result in Q16.16 with exact wide arithmetic and compares it.
// Depends on situ_pkg for the coordinate width and FRAC_BITS.
`timescale 1ns / 100ps
module situ_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic signed [situ_pkg::COORD_W-1:0] a_x,
    input  logic signed [situ_pkg::COORD_W-1:0] a_y,
    input  logic signed [situ_pkg::COORD_W-1:0] b_x,
    input  logic signed [situ_pkg::COORD_W-1:0] b_y,
    input  logic signed [situ_pkg::COORD_W-1:0] c_x,
    input  logic signed [situ_pkg::COORD_W-1:0] c_y,
    input  logic signed [situ_pkg::COORD_W-1:0] d_x,
    input  logic signed [situ_pkg::COORD_W-1:0] d_y,
    input  logic                                done,
    input  logic signed [situ_pkg::COORD_W-1:0] frac_ab,
    input  logic signed [situ_pkg::COORD_W-1:0] frac_cd,
    input  logic signed [situ_pkg::COORD_W-1:0] cross_x,
    input  logic signed [situ_pkg::COORD_W-1:0] cross_y,
    input  logic                                segments_meet,
    output int                                  fail_count,
    output int                                  pending_count
);
    localparam int FB = situ_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [31:0] f_ab;
        logic signed [31:0] f_cd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               meet;
    } crossing_t;

    crossing_t crossing_q[$];

    // Truncated (num << FB) / den, saturated to 32 bits
    function automatic logic signed [31:0] scaled_quotient(logic signed [127:0] num,
                                                           logic signed [127:0] den);
        logic signed [127:0] q;
        q = (num <<< FB) / den;
        if (q > 128'sd2147483647) return 32'h7FFF_FFFF;
        if (q < -128'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    // base + floor(frac * delta / 2^FB), saturated
    function automatic logic signed [31:0] point_coord(logic signed [31:0] base,
                                                       logic signed [31:0] frac,
                                                       logic signed [127:0] delta);
        logic signed [127:0] s;
        s = base + ((frac * delta) >>> FB);
        if (s > 128'sd2147483647) return 32'h7FFF_FFFF;
        if (s < -128'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic crossing_t predict_crossing(
        logic signed [31:0] ax, logic signed [31:0] ay,
        logic signed [31:0] bx, logic signed [31:0] by,
        logic signed [31:0] cx, logic signed [31:0] cy,
        logic signed [31:0] dx, logic signed [31:0] dy);
        logic signed [127:0] abx, aby, cdx, cdy, den, n_ab, n_cd, d_cd;
        crossing_t r;
        abx = bx; abx = abx - ax;
        aby = by; aby = aby - ay;
        cdx = dx; cdx = cdx - cx;
        cdy = dy; cdy = cdy - cy;
        den = abx * cdy - aby * cdx;
        r = '0;
        r.meet = 1'b1;
        if (den != 0) begin
            n_ab = (128'(ay) - cy) * cdx - (128'(ax) - cx) * cdy;
            n_cd = (128'(cy) - ay) * abx - (128'(cx) - ax) * aby;
            d_cd = -den;
            r.f_ab = scaled_quotient(n_ab, den);
            r.f_cd = scaled_quotient(n_cd, d_cd);
            // exact ratio test: 0 <= n/d <= 1
            r.meet = (n_ab == 0 || ((n_ab < 0) == (den < 0)
                        && (n_ab < 0 ? -n_ab : n_ab) <= (den < 0 ? -den : den)))
                  && (n_cd == 0 || ((n_cd < 0) == (d_cd < 0)
                        && (n_cd < 0 ? -n_cd : n_cd) <= (d_cd < 0 ? -d_cd : d_cd)));
        end
        r.px = point_coord(ax, r.f_ab, abx);
        r.py = point_coord(ay, r.f_ab, aby);
        return r;
    endfunction

    assign pending_count = crossing_q.size();

    always @(posedge clk or negedge rst_n) begin
        crossing_t exp_r;
        if (!rst_n) begin
            fail_count <= 0;
        end
        else begin
            // result transfer checked against oldest expectation
            if (done) begin
                if (crossing_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: frac_ab=%h", frac_ab);
                    fail_count <= fail_count + 1;
                end
                else begin
                    exp_r = crossing_q.pop_front();
                    if (exp_r.f_ab !== frac_ab || exp_r.f_cd !== frac_cd
                        || exp_r.px !== cross_x || exp_r.py !== cross_y
                        || exp_r.meet !== segments_meet) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
                                     exp_r.f_ab, exp_r.f_cd, exp_r.px, exp_r.py,
                                     exp_r.meet, frac_ab, frac_cd, cross_x, cross_y,
                                     segments_meet);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // input transfer
            if (start && !busy)
                crossing_q.push_back(predict_crossing(a_x, a_y, b_x, b_y,
                                                      c_x, c_y, d_x, d_y));
        end
    end
endmodule

// ===== verif/tb_segment_intersection_test_unit.sv =====
// Testbench top for segment_intersection_test_unit: drives directed and random
// segment pairs with random idle gaps and gives the verdict from situ_checker.
// Depends on situ_pkg, the RTL and situ_checker.
`timescale 1ns / 100ps
module tb_segment_intersection_test_unit;
    localparam int LATENCY  = 40;
    localparam int WD_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done, segments_meet;
    logic signed [31:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0;
    logic signed [31:0] c_x = '0, c_y = '0, d_x = '0, d_y = '0;
    logic signed [31:0] frac_ab, frac_cd, cross_x, cross_y;
    int fail_count, pending_count;
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    segment_intersection_test_unit u_dut (.*);
    situ_checker u_checker (.*);

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("segment_intersection_test_unit regression: fail");
            $finish;
        end
    end

    // one coordinate: extremes, small Q16.16 values or full random
    function automatic logic [31:0] rand_coord(bit wide);
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4: return wide ? $urandom : 32'($signed($urandom_range(0, 40)) - 20) << 16;
            default: return wide ? $urandom
                                 : 32'($signed($urandom_range(0, 2097152)) - 1048576);
        endcase
    endfunction

    task automatic send_pair(logic [31:0] ax, ay, bx, by, cx, cy, dx, dy);
        start <= 1'b1;
        a_x <= ax; a_y <= ay; b_x <= bx; b_y <= by;
        c_x <= cx; c_y <= cy; d_x <= dx; d_y <= dy;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic idle_gap(bit quiet);
        int n;
        n = 0;
        if (!quiet) while ($urandom_range(0, 99) < 9) n++;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: crossing, parallel, degenerate, extremes
        send_pair(0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 0);
        send_pair(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000);
        send_pair(5, 5, 5, 5, 7, 7, 7, 7);
        send_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 32'h10000, 32'hFFFF0000);
        send_pair(0, 0, 32'h10000, 0, 32'h30000, 32'h10000, 32'h30000, 32'hFFFF0000);
        send_pair(0, 0, 1, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_pair(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h20000, 32'h1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        // random pairs; first stretch back to back
        for (k = 0; k < 540; k++) begin
            idle_gap(k < 150);
            send_pair(rand_coord(k % 5 == 0), rand_coord(k % 5 == 0),
                      rand_coord(k % 5 == 0), rand_coord(k % 5 == 0),
                      rand_coord(k % 5 == 0), rand_coord(k % 5 == 0),
                      rand_coord(k % 5 == 0), rand_coord(k % 5 == 0));
        end
        start <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0) $display("segment_intersection_test_unit regression: pass");
        else $display("segment_intersection_test_unit regression: fail");
        $finish;
    end
endmodule

// ===== segment_intersection_test_unit.f =====
rtl/core/situ_pkg.sv
rtl/core/situ_cell.sv
rtl/core/segment_intersection_test_unit.sv
verif/situ_checker.sv
verif/tb_segment_intersection_test_unit.sv
